// ----- src/sacl_pkg.sv -----
package sacl_pkg;

  localparam int ADDR_W = 24;
  localparam int CNT_W  = 32;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_COLD  = 2'd1,
    OUT_CLEAN = 2'd2,
    OUT_DIRTY = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              write_op;
  } sacl_in_t;

  typedef struct packed {
    outcome_t          outcome;
    logic [1:0]        way_used;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  replace_miss_total;
    logic [CNT_W-1:0]  compulsory_total;
    logic [CNT_W-1:0]  dirty_replace_total;
  } sacl_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_UPDATE = 2'd2
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear_wr;
    logic commit;
  } sacl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } sacl_sts_t;

endpackage

// ----- src/sacl_ram.sv -----
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/sacl_ctrl.sv -----
module sacl_ctrl import sacl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  sacl_sts_t sts,
  output sacl_cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // result slot must be free or draining this cycle
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase

    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ----- src/sacl_datapath.sv -----
module sacl_datapath import sacl_pkg::*; #(
  parameter int SETS         = 64,
  parameter int WAYS         = 4,
  parameter int OFFSET_BITS  = 4,
  parameter int ADDRESS_BITS = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  sacl_in_t  in_data,
  input  sacl_cmd_t cmd,
  output sacl_sts_t sts,
  output sacl_out_t out_data
);

  localparam int IDX_W   = $clog2(SETS);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int RANK_W  = $clog2(WAYS);
  localparam int TAG_RAW = ADDRESS_BITS - OFFSET_BITS - IDX_W;
  localparam int TAG_W   = (TAG_RAW < 1) ? 1 : TAG_RAW;
  localparam int META_W  = RANK_W + 2;
  localparam logic [RANK_W-1:0] TOP_RANK = RANK_W'(WAYS - 1);

  // address split
  logic [ADDRESS_BITS-1:0] addr_ext;
  logic [ADDRESS_BITS-1:0] addr_idx_sh;
  logic [ADDRESS_BITS-1:0] addr_tag_sh;
  logic [IDX_W-1:0]        raw_idx;
  logic [IDX_W-1:0]        in_set;
  logic [TAG_W-1:0]        in_tag;

  for (genvar i = 0; i < ADDRESS_BITS; i++) begin : g_addr
    if (i < ADDR_W) begin : g_bit
      assign addr_ext[i] = in_data.address[i];
    end else begin : g_zero
      assign addr_ext[i] = 1'b0;
    end
  end

  assign addr_idx_sh = addr_ext >> OFFSET_BITS;
  assign addr_tag_sh = addr_ext >> (OFFSET_BITS + IDX_W);
  assign raw_idx     = addr_idx_sh[IDX_W-1:0];
  // wrap for a set count that is not a power of two
  assign in_set = ({1'b0, raw_idx} >= (IDX_W + 1)'(SETS)) ? IDX_W'(raw_idx - IDX_W'(SETS))
                                                           : raw_idx;
  assign in_tag = (TAG_RAW < 1) ? '0 : addr_tag_sh[TAG_W-1:0];

  // latched access
  logic [IDX_W-1:0] set_reg;
  logic [TAG_W-1:0] tag_reg;
  logic             wr_reg;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_reg <= in_set;
      tag_reg <= in_tag;
      wr_reg  <= in_data.write_op;
    end
  end

  // clearing pass over the state rows
  logic [IDX_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt <= IDX_W'(clr_cnt + 1'b1);
    end
  end

  assign sts.clear_last = (clr_cnt == IDX_W'(SETS - 1));

  // row memories
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         meta_wr_addr;
  logic [WAYS*TAG_W-1:0]    tag_rd;
  logic [WAYS*TAG_W-1:0]    tag_wr;
  logic [WAYS*META_W-1:0]   meta_rd;
  logic [WAYS*META_W-1:0]   meta_new;
  logic [WAYS*META_W-1:0]   meta_wr;

  assign rd_addr      = cmd.capture ? in_set : set_reg;
  assign meta_wr_addr = cmd.clear_wr ? clr_cnt : set_reg;
  assign meta_wr      = cmd.clear_wr ? '0 : meta_new;

  sacl_ram #(.WIDTH(WAYS*TAG_W), .DEPTH(SETS)) u_tag_ram (
    .clk     (clk),
    .wr_en   (cmd.commit),
    .wr_addr (set_reg),
    .wr_data (tag_wr),
    .rd_addr (rd_addr),
    .rd_data (tag_rd)
  );

  sacl_ram #(.WIDTH(WAYS*META_W), .DEPTH(SETS)) u_meta_ram (
    .clk     (clk),
    .wr_en   (cmd.commit | cmd.clear_wr),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr),
    .rd_addr (rd_addr),
    .rd_data (meta_rd)
  );

  // lookup and update
  logic [WAYS-1:0]   vld, drt;
  logic [RANK_W-1:0] rnk [WAYS];
  logic [TAG_W-1:0]  tags [WAYS];
  logic              hit, free_found;
  logic [WAY_W-1:0]  hit_way, free_way, victim, way;
  logic [RANK_W-1:0] min_rank, old_rank;
  outcome_t          outcome;

  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      vld[w]  = meta_rd[w*META_W + RANK_W + 1];
      drt[w]  = meta_rd[w*META_W + RANK_W];
      rnk[w]  = meta_rd[w*META_W +: RANK_W];
      tags[w] = tag_rd[w*TAG_W +: TAG_W];
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && vld[w] && (tags[w] == tag_reg)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!free_found && !vld[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
    // least recent way, lowest index on a tie
    victim   = '0;
    min_rank = rnk[0];
    for (int w = 1; w < WAYS; w++) begin
      if (rnk[w] < min_rank) begin
        victim   = WAY_W'(w);
        min_rank = rnk[w];
      end
    end

    if (hit) begin
      way     = hit_way;
      outcome = OUT_HIT;
    end else if (free_found) begin
      way     = free_way;
      outcome = OUT_COLD;
    end else begin
      way     = victim;
      outcome = drt[victim] ? OUT_DIRTY : OUT_CLEAN;
    end
    old_rank = rnk[hit_way];

    for (int w = 0; w < WAYS; w++) begin
      logic [RANK_W-1:0] r;
      logic              v, d;
      logic [TAG_W-1:0]  t;
      r = rnk[w];
      v = vld[w];
      d = drt[w];
      t = tags[w];
      if (hit) begin
        if (WAY_W'(w) == way) begin
          r = TOP_RANK;
          d = d | wr_reg;
        end else if (v && (r > old_rank)) begin
          r = RANK_W'(r - 1'b1);
        end
      end else begin
        if (v && (r != '0)) begin
          r = RANK_W'(r - 1'b1);
        end
        if (WAY_W'(w) == way) begin
          r = TOP_RANK;
          v = 1'b1;
          d = wr_reg;
          t = tag_reg;
        end
      end
      meta_new[w*META_W +: META_W] = {v, d, r};
      tag_wr[w*TAG_W +: TAG_W]     = t;
    end
  end

  // saturating totals
  logic [CNT_W-1:0] hit_cnt, miss_cnt, cold_cnt, dirty_cnt;
  logic [CNT_W-1:0] hit_next, miss_next, cold_next, dirty_next;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
    sat_inc = (en && (v != '1)) ? CNT_W'(v + 1'b1) : v;
  endfunction

  assign hit_next   = sat_inc(hit_cnt, outcome == OUT_HIT);
  assign cold_next  = sat_inc(cold_cnt, outcome == OUT_COLD);
  assign miss_next  = sat_inc(miss_cnt, (outcome == OUT_CLEAN) || (outcome == OUT_DIRTY));
  assign dirty_next = sat_inc(dirty_cnt, outcome == OUT_DIRTY);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      cold_cnt  <= '0;
      dirty_cnt <= '0;
    end else if (cmd.commit) begin
      hit_cnt   <= hit_next;
      miss_cnt  <= miss_next;
      cold_cnt  <= cold_next;
      dirty_cnt <= dirty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.outcome             <= outcome;
      out_data.way_used            <= 2'(way);
      out_data.hit_total           <= hit_next;
      out_data.replace_miss_total  <= miss_next;
      out_data.compulsory_total    <= cold_next;
      out_data.dirty_replace_total <= dirty_next;
    end
  end

endmodule

// ----- src/set_assoc_cache_lru_tags.sv -----
// channel   signals                          beat
// -------   ------------------------------   --------------------------------------
// in        in_valid / in_ready / in_data    one access: address, write_op
// out       out_valid / out_ready / out_data outcome, way, four running totals
//
// each access is accepted in the idle state, where its set row is read from the
// registered tag and state row memories; in the update state the row is updated
// and the result registered, and no new access is accepted until that update
// commits
// after reset a clearing pass writes the state rows, with in_ready low
// a waiting result holds the next access in its update cycle until out_ready
module set_assoc_cache_lru_tags import sacl_pkg::*; #(
  parameter int SETS         = 64,
  parameter int WAYS         = 4,
  parameter int OFFSET_BITS  = 4,
  parameter int ADDRESS_BITS = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sacl_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output sacl_out_t out_data
);

  sacl_cmd_t cmd;
  sacl_sts_t sts;

  // sequencer: clearing pass, accept, update
  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tag compare, lru ranks, totals and the result register
  sacl_datapath #(
    .SETS         (SETS),
    .WAYS         (WAYS),
    .OFFSET_BITS  (OFFSET_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- test/set_assoc_cache_lru_tags_tb.sv -----
`timescale 1ns / 100ps

module set_assoc_cache_lru_tags_tb;
  import sacl_pkg::*;

  // address split at the default geometry: 4 offset bits, 6 index bits, 14 tag bits
  localparam int NUM_SETS   = 64;
  localparam int NUM_WAYS   = 4;
  localparam int OFS_W      = 4;
  localparam int IDX_W      = 6;
  localparam int TAG_W      = ADDR_W - OFS_W - IDX_W;
  localparam int TOP_RANK   = NUM_WAYS - 1;
  localparam int NUM_DIR    = 19;
  localparam int NUM_RAND   = 530;
  localparam int CALM_FROM  = 470;    // random beats from here on go without idling
  localparam int HOLD_AT    = 150;    // result count that starts the long receiver hold
  localparam int HOLD_LEN   = 120;
  localparam int STUCK_MAX  = 1000;   // cycles with no beat on either channel
  localparam int TAIL_WAIT  = 8;

  // one row of the directed table; outcome and way are only checked from the
  // row when typed is set, otherwise they come from the shadow cache
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              write_op;
    logic              typed;
    outcome_t          outcome;
    logic [1:0]        way;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sacl_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sacl_out_t out_data;

  // shadow copy of the tag store and the running totals
  logic [TAG_W-1:0] shadow_tag   [NUM_SETS][NUM_WAYS];
  logic             shadow_valid [NUM_SETS][NUM_WAYS];
  logic             shadow_dirty [NUM_SETS][NUM_WAYS];
  logic [1:0]       shadow_rank  [NUM_SETS][NUM_WAYS];
  logic [CNT_W-1:0] hit_cnt, repl_cnt, cold_cnt, dirty_cnt;

  sacl_out_t pending_results[$];
  dir_row_t  dir_rows[NUM_DIR];
  logic [IDX_W-1:0] hot_sets[4];
  logic [TAG_W-1:0] hot_tags[6];

  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  stuck_cycles   = 0;
  bit  calm           = 1'b0;
  bit  hold_done      = 1'b0;

  set_assoc_cache_lru_tags dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // one lookup against the shadow cache: hit / fill / evict, lru ranks and totals
  function automatic sacl_out_t predict_access(input sacl_in_t acc);
    logic [IDX_W-1:0] set_idx;
    logic [TAG_W-1:0] tag_val;
    logic [1:0]       old_rank;
    int               way_sel;
    bit               hit;
    bit               free;
    sacl_out_t        res;
    set_idx = acc.address[OFS_W +: IDX_W];
    tag_val = acc.address[ADDR_W-1 -: TAG_W];
    hit     = 1'b0;
    free    = 1'b0;
    way_sel = 0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag_val) begin
        hit     = 1'b1;
        way_sel = w;
      end
    end
    if (hit) begin
      // ways above the hit way's old rank move down one, hit way goes to the top
      old_rank = shadow_rank[set_idx][way_sel];
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (w != way_sel && shadow_valid[set_idx][w] && shadow_rank[set_idx][w] > old_rank)
          shadow_rank[set_idx][w]--;
      end
      shadow_rank[set_idx][way_sel] = 2'(TOP_RANK);
      if (acc.write_op)
        shadow_dirty[set_idx][way_sel] = 1'b1;
      hit_cnt     = sat_inc(hit_cnt);
      res.outcome = OUT_HIT;
    end else begin
      // first invalid way, else lowest rank with the lowest way winning ties
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!free && !shadow_valid[set_idx][w]) begin
          free    = 1'b1;
          way_sel = w;
        end
      end
      if (!free) begin
        for (int w = 1; w < NUM_WAYS; w++) begin
          if (shadow_rank[set_idx][w] < shadow_rank[set_idx][way_sel])
            way_sel = w;
        end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (shadow_valid[set_idx][w] && shadow_rank[set_idx][w] != 0)
          shadow_rank[set_idx][w]--;
      end
      if (free) begin
        cold_cnt    = sat_inc(cold_cnt);
        res.outcome = OUT_COLD;
      end else if (shadow_dirty[set_idx][way_sel]) begin
        // the evicted line decides clean or dirty, not the incoming access
        repl_cnt    = sat_inc(repl_cnt);
        dirty_cnt   = sat_inc(dirty_cnt);
        res.outcome = OUT_DIRTY;
      end else begin
        repl_cnt    = sat_inc(repl_cnt);
        res.outcome = OUT_CLEAN;
      end
      shadow_tag[set_idx][way_sel]   = tag_val;
      shadow_valid[set_idx][way_sel] = 1'b1;
      shadow_dirty[set_idx][way_sel] = acc.write_op;
      shadow_rank[set_idx][way_sel]  = 2'(TOP_RANK);
    end
    res.way_used            = way_sel[1:0];
    res.hit_total           = hit_cnt;
    res.replace_miss_total  = repl_cnt;
    res.compulsory_total    = cold_cnt;
    res.dirty_replace_total = dirty_cnt;
    return res;
  endfunction

  // offer one access beat, with an optional idle burst in front of it;
  // valid stays high straight into the next beat when there is no gap
  task automatic issue_access(input sacl_in_t acc, input bit typed, input outcome_t outc,
                              input logic [1:0] way);
    sacl_out_t want;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= acc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_access(acc);
    if (typed) begin
      want.outcome  = outc;
      want.way_used = way;
    end
    pending_results.push_back(want);
    @(negedge clk);
  endtask

  // result side: random stall bursts, one long hold so the block backs up
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!rst && !hold_done && results_seen >= HOLD_AT) begin
        hold_done  = 1'b1;
        stall_left = HOLD_LEN;
      end else if (!rst && stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare every result beat with the oldest prediction
  always @(posedge clk) begin
    sacl_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: outcome %0d way %0d",
                   out_data.outcome, out_data.way_used);
      end else begin
        want = pending_results.pop_front();
        if (out_data.outcome !== want.outcome || out_data.way_used !== want.way_used ||
            out_data.hit_total !== want.hit_total ||
            out_data.replace_miss_total !== want.replace_miss_total ||
            out_data.compulsory_total !== want.compulsory_total ||
            out_data.dirty_replace_total !== want.dirty_replace_total) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d mismatch (exp/got): outcome %0d/%0d way %0d/%0d",
                     results_seen, want.outcome, out_data.outcome,
                     want.way_used, out_data.way_used);
            $display("  hits %0d/%0d repl %0d/%0d cold %0d/%0d dirty %0d/%0d",
                     want.hit_total, out_data.hit_total,
                     want.replace_miss_total, out_data.replace_miss_total,
                     want.compulsory_total, out_data.compulsory_total,
                     want.dirty_replace_total, out_data.dirty_replace_total);
          end
        end
      end
    end
  end

  // watchdog: too long without a beat on either channel ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_MAX) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sacl_in_t acc;
    // empty shadow cache and totals
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        shadow_tag[s][w]   = '0;
        shadow_valid[s][w] = 1'b0;
        shadow_dirty[s][w] = 1'b0;
        shadow_rank[s][w]  = '0;
      end
    end
    hit_cnt   = '0;
    repl_cnt  = '0;
    cold_cnt  = '0;
    dirty_cnt = '0;

    // directed table: address, write_op, typed, outcome, way
    // set 0 is filled, hit through the offset, then walked through every eviction
    dir_rows[0]  = {24'h000000, 1'b0, 1'b1, OUT_COLD,  2'd0}; // first access after reset
    dir_rows[1]  = {24'h000000, 1'b1, 1'b1, OUT_HIT,   2'd0}; // write hit, way 0 dirty
    dir_rows[2]  = {24'h000400, 1'b0, 1'b0, OUT_HIT,   2'd0};
    dir_rows[3]  = {24'h000800, 1'b1, 1'b0, OUT_HIT,   2'd0}; // write fill, born dirty
    dir_rows[4]  = {24'h000C00, 1'b0, 1'b0, OUT_HIT,   2'd0}; // set 0 now full
    dir_rows[5]  = {24'h00000F, 1'b0, 1'b0, OUT_HIT,   2'd0}; // hit on lru way, max offset
    dir_rows[6]  = {24'h001000, 1'b0, 1'b1, OUT_CLEAN, 2'd1}; // lru way 1 is clean
    dir_rows[7]  = {24'h001400, 1'b0, 1'b1, OUT_DIRTY, 2'd2}; // evicts the write-filled line
    dir_rows[8]  = {24'h001800, 1'b0, 1'b1, OUT_CLEAN, 2'd3};
    dir_rows[9]  = {24'h001C00, 1'b1, 1'b1, OUT_DIRTY, 2'd0}; // victim dirtied by write hit
    dir_rows[10] = {24'hFFFFFF, 1'b1, 1'b1, OUT_COLD,  2'd0}; // all ones, top set
    dir_rows[11] = {24'hFFFFF0, 1'b0, 1'b1, OUT_HIT,   2'd0};
    dir_rows[12] = {24'h0003F0, 1'b0, 1'b1, OUT_COLD,  2'd1}; // tag 0 in the top set
    dir_rows[13] = {24'h800000, 1'b0, 1'b0, OUT_HIT,   2'd0};
    dir_rows[14] = {24'h7FFFFF, 1'b1, 1'b0, OUT_HIT,   2'd0};
    dir_rows[15] = {24'h555555, 1'b1, 1'b0, OUT_HIT,   2'd0};
    dir_rows[16] = {24'hAAAAAA, 1'b0, 1'b0, OUT_HIT,   2'd0};
    dir_rows[17] = {24'h555555, 1'b0, 1'b0, OUT_HIT,   2'd0}; // same line as row 15 again, one other access in between
    dir_rows[18] = {24'h555550, 1'b1, 1'b0, OUT_HIT,   2'd0};

    // small pools of sets and tags so random traffic keeps hitting and evicting
    foreach (hot_sets[i]) hot_sets[i] = IDX_W'($urandom_range(0, NUM_SETS - 1));
    foreach (hot_tags[i]) hot_tags[i] = TAG_W'($urandom());

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIR; i++) begin
      acc.address  = dir_rows[i].address;
      acc.write_op = dir_rows[i].write_op;
      issue_access(acc, dir_rows[i].typed, dir_rows[i].outcome, dir_rows[i].way);
    end

    for (int i = 0; i < NUM_RAND; i++) begin
      if (i == CALM_FROM)
        calm = 1'b1;
      // now and then a pool tag moves so fresh lines keep arriving
      if ($urandom_range(0, 39) == 0)
        hot_tags[$urandom_range(0, 5)] = TAG_W'($urandom());
      if ($urandom_range(0, 9) < 8)
        acc.address = {hot_tags[$urandom_range(0, 5)], hot_sets[$urandom_range(0, 3)],
                       OFS_W'($urandom())};
      else
        acc.address = ADDR_W'($urandom());
      acc.write_op = 1'($urandom_range(0, 1));
      issue_access(acc, 1'b0, OUT_HIT, 2'd0);
    end
    in_valid <= 1'b0;

    // drain, then keep watching for a tail period to catch any stray beat
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
